/* hw/rtl/fnebb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fnebb_pkg;

   localparam int ROW_W = 10;
   localparam int COL_W = 6;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 10;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;

   localparam logic [CSR_ADDR_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT = 1'b1;

   localparam logic [COL_W-1:0] WIDTH_RESET  = 6'd10;
   localparam logic [ROW_W-1:0] HEIGHT_RESET = 10'd5;

   // land pixel survives with at least this many land neighbors
   localparam logic [2:0] LAND_MIN = 3'd2;

   // write side of one line-buffer column
   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] col;
      logic             mid;
      logic             up;
   } line_wr_type;

   typedef struct packed {
      logic mid;
      logic up;
   } line_bits_type;

   // one eroded pixel handed to the box tracker
   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             land;
      logic             last;
   } pix_type;

   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] min_row;
      logic [ROW_W-1:0] max_row;
      logic [COL_W-1:0] min_col;
      logic [COL_W-1:0] max_col;
   } box_type;

   typedef struct packed {
      logic             emit;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             mid;
      logic             up;
      logic             down;
      logic             left;
      logic             has_right;
   } win_type;

   function automatic logic survives(input logic mid, input logic up, input logic down,
                                     input logic left, input logic right);
      logic [2:0] cnt;
      cnt = {2'b00, up} + {2'b00, down} + {2'b00, left} + {2'b00, right};
      return mid && (cnt >= LAND_MIN);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/four_neighbor_erosion_bbox.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Transfer when             Payload
// req_      in   req_tvalid & req_tready   tdata[0] is_land
// rsp_      out  rsp_tvalid & rsp_tready   tdata row/col/land/box, tlast = last
// csr_      in   csr_we                    csr_addr 0 width, 1 height
//
// One pixel per cycle while the result side keeps up; a result passes through the
// window stage, then the output register.
// After the last pixel of a map the final row drains from the line cells at one
// column per cycle while the result side keeps up, with req_tready low.
// Reset clears counters, box and handshakes and loads width 10, height 5;
// the line cells are not reset. A stalled output register holds the window
// stage and, behind it, the input.
module four_neighbor_erosion_bbox #(
   parameter int MAX_WIDTH = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [fnebb_pkg::REQ_DATA_W-1:0]     req_tdata,  // [0] is_land
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [9:0] out_row, [15:10] out_col, [16] land_after, [17] box_valid,
   // [27:18] min_row, [37:28] max_row, [43:38] min_col, [49:44] max_col
   output logic [fnebb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   input  wire                                 csr_we,
   input  wire [fnebb_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire [fnebb_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fnebb_pkg::*;

   localparam logic [COL_W-1:0] MAXW = COL_W'(MAX_WIDTH);

   // configuration
   logic [COL_W-1:0] width_ff;
   logic [ROW_W-1:0] height_ff;
   logic [COL_W-1:0] w_eff;
   logic [ROW_W-1:0] h_eff;

   // raster position and drain of the final row
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;
   logic             flush_ff;
   logic [COL_W-1:0] fcol_ff;
   logic [ROW_W-1:0] frow_ff;

   // prefetched line-buffer bits for the next column, and left neighbor
   logic             mid_rd_ff, mid_rd_in;
   logic             up_rd_ff, up_rd_in;
   logic             left_ff;

   // window stage
   logic             b_valid_ff;
   win_type          b_ff, b_in;

   // output register
   logic             rsp_valid_ff;
   logic [ROW_W-1:0] o_row_ff;
   logic [COL_W-1:0] o_col_ff;
   logic             o_land_ff;
   logic             o_last_ff;
   box_type          o_box_ff;

   logic             x;
   logic             last_col, last_row, f_last;
   logic             b_go, a_free, accept, fl_go, a_step;
   logic [COL_W-1:0] nc, rd_col;
   logic             b_right, b_land;
   line_wr_type      wr;
   line_bits_type    cell_bits [MAX_WIDTH];
   line_bits_type    rd_bits;
   pix_type          pix;
   box_type          box;

   assign x = req_tdata[0];

   always_comb begin
      if (width_ff == '0) w_eff = COL_W'(1);
      else if (width_ff > MAXW) w_eff = MAXW;
      else w_eff = width_ff;
      h_eff = (height_ff == '0) ? ROW_W'(1) : height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_WIDTH:  width_ff  <= csr_wdata[COL_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshakes
   assign b_go       = !rsp_valid_ff || rsp_tready;
   assign a_free     = !b_valid_ff || b_go;
   assign req_tready = a_free && !flush_ff;
   assign accept     = req_tvalid && req_tready;
   assign fl_go      = flush_ff && a_free;
   assign a_step     = accept || fl_go;

   assign last_col = ({1'b0, col_ff} + 7'd1) >= {1'b0, w_eff};
   assign last_row = ({1'b0, row_ff} + 11'd1) >= {1'b0, h_eff};
   assign f_last   = ({1'b0, fcol_ff} + 7'd1) >= {1'b0, w_eff};
   assign nc       = last_col ? '0 : col_ff + COL_W'(1);
   assign rd_col   = flush_ff ? (f_last ? '0 : fcol_ff + COL_W'(1)) : nc;

   // line cells: one column each
   always_comb begin
      wr.en  = accept;
      wr.col = col_ff;
      wr.mid = x;
      wr.up  = mid_rd_ff;
   end

   for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_cell
      fnebb_cell #(.INDEX(j)) u_cell (
         .clock   (clock),
         .wr      (wr),
         .rd_col  (rd_col),
         .rd_bits (cell_bits[j])
      );
   end

   always_comb begin
      rd_bits = '0;
      for (int j = 0; j < MAX_WIDTH; j++) begin
         rd_bits = rd_bits | cell_bits[j];
      end
   end

   // single-column row: the next column is the one being written now
   always_comb begin
      if (accept && (nc == col_ff)) begin
         mid_rd_in = x;
         up_rd_in  = mid_rd_ff;
      end else begin
         mid_rd_in = rd_bits.mid;
         up_rd_in  = rd_bits.up;
      end
   end

   always_comb begin
      if (flush_ff) begin
         b_in.emit      = 1'b1;
         b_in.last      = f_last;
         b_in.row       = frow_ff;
         b_in.col       = fcol_ff;
         b_in.mid       = mid_rd_ff;
         b_in.up        = (frow_ff != '0) ? up_rd_ff : 1'b0;
         b_in.down      = 1'b0;
         b_in.left      = (fcol_ff != '0) ? left_ff : 1'b0;
         b_in.has_right = !f_last;
      end else begin
         b_in.emit      = (row_ff != '0);
         b_in.last      = 1'b0;
         b_in.row       = row_ff - ROW_W'(1);
         b_in.col       = col_ff;
         b_in.mid       = mid_rd_ff;
         b_in.up        = (row_ff >= ROW_W'(2)) ? up_rd_ff : 1'b0;
         b_in.down      = x;
         b_in.left      = (col_ff != '0) ? left_ff : 1'b0;
         b_in.has_right = !last_col;
      end
   end

   always_ff @(posedge clock) begin
      if (a_step) begin
         mid_rd_ff <= mid_rd_in;
         up_rd_ff  <= up_rd_in;
         left_ff   <= mid_rd_ff;
         b_ff      <= b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         flush_ff   <= 1'b0;
         fcol_ff    <= '0;
         frow_ff    <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (last_col) begin
               col_ff <= '0;
               if (last_row) begin
                  row_ff   <= '0;
                  flush_ff <= 1'b1;
                  fcol_ff  <= '0;
                  frow_ff  <= row_ff;
               end else begin
                  row_ff <= row_ff + ROW_W'(1);
               end
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end else if (fl_go) begin
            if (f_last) flush_ff <= 1'b0;
            else fcol_ff <= fcol_ff + COL_W'(1);
         end
         if (a_step) b_valid_ff <= 1'b1;
         else if (b_go) b_valid_ff <= 1'b0;
      end
   end

   // window stage: right neighbor is the column read during the last step
   assign b_right = b_ff.has_right & mid_rd_ff;
   assign b_land  = survives(b_ff.mid, b_ff.up, b_ff.down, b_ff.left, b_right);

   always_comb begin
      pix.en   = b_valid_ff && b_go && b_ff.emit;
      pix.row  = b_ff.row;
      pix.col  = b_ff.col;
      pix.land = b_land;
      pix.last = b_ff.last;
   end

   fnebb_bbox u_bbox (
      .clock (clock),
      .reset (reset),
      .pix   (pix),
      .box   (box)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_go) begin
         rsp_valid_ff <= b_valid_ff && b_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (pix.en) begin
         o_row_ff  <= b_ff.row;
         o_col_ff  <= b_ff.col;
         o_land_ff <= b_land;
         o_last_ff <= b_ff.last;
         o_box_ff  <= b_ff.last ? box : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {6'd0, o_box_ff.max_col, o_box_ff.min_col, o_box_ff.max_row,
                        o_box_ff.min_row, o_box_ff.valid, o_land_ff, o_col_ff, o_row_ff};

endmodule

`default_nettype wire

/* hw/rtl/fnebb_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One column of the two line buffers. Read data is gated by the column
// select so the row of cells can be OR-combined.
module fnebb_cell #(
   parameter int INDEX = 0
) (
   input  wire                            clock,
   input  wire fnebb_pkg::line_wr_type    wr,
   input  wire [fnebb_pkg::COL_W-1:0]     rd_col,
   output fnebb_pkg::line_bits_type       rd_bits
);
   import fnebb_pkg::*;

   localparam logic [COL_W-1:0] MY_COL = COL_W'(INDEX);

   logic mid_ff;
   logic up_ff;

   always_ff @(posedge clock) begin
      if (wr.en && (wr.col == MY_COL)) begin
         mid_ff <= wr.mid;
         up_ff  <= wr.up;
      end
   end

   always_comb begin
      rd_bits.mid = mid_ff & (rd_col == MY_COL);
      rd_bits.up  = up_ff & (rd_col == MY_COL);
   end

endmodule

`default_nettype wire

/* hw/rtl/fnebb_bbox.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounding box of surviving land. The output already includes the pixel
// being presented, so the final result carries the complete box.
module fnebb_bbox (
   input  wire                       clock,
   input  wire                       reset,
   input  wire fnebb_pkg::pix_type   pix,
   output fnebb_pkg::box_type        box
);
   import fnebb_pkg::*;

   logic [ROW_W-1:0] min_row_ff, min_row_in;
   logic [ROW_W-1:0] max_row_ff, max_row_in;
   logic [COL_W-1:0] min_col_ff, min_col_in;
   logic [COL_W-1:0] max_col_ff, max_col_in;
   logic             any_ff, any_in;

   always_comb begin
      min_row_in = min_row_ff;
      max_row_in = max_row_ff;
      min_col_in = min_col_ff;
      max_col_in = max_col_ff;
      any_in     = any_ff;
      if (pix.land) begin
         if (pix.row < min_row_ff) min_row_in = pix.row;
         if (pix.row > max_row_ff) max_row_in = pix.row;
         if (pix.col < min_col_ff) min_col_in = pix.col;
         if (pix.col > max_col_ff) max_col_in = pix.col;
         any_in = 1'b1;
      end
      box.valid   = any_in;
      box.min_row = any_in ? min_row_in : '0;
      box.max_row = any_in ? max_row_in : '0;
      box.min_col = any_in ? min_col_in : '0;
      box.max_col = any_in ? max_col_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (pix.en && pix.last)) begin
         min_row_ff <= '1;
         max_row_ff <= '0;
         min_col_ff <= '1;
         max_col_ff <= '0;
         any_ff     <= 1'b0;
      end else if (pix.en) begin
         min_row_ff <= min_row_in;
         max_row_ff <= max_row_in;
         min_col_ff <= min_col_in;
         max_col_ff <= max_col_in;
         any_ff     <= any_in;
      end
   end

endmodule

`default_nettype wire

/* test/four_neighbor_erosion_bbox_tb.sv */
`timescale 1ns / 1ps

module four_neighbor_erosion_bbox_tb;

   localparam int MAX_W = 32;
   localparam int HOLD_CYCLES = 8;
   localparam int STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [fnebb_pkg::REQ_DATA_W-1:0]    req_tdata = '0;   // [0] is_land
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // [9:0] out_row, [15:10] out_col, [16] land_after, [17] box_valid,
   // [27:18] min_row, [37:28] max_row, [43:38] min_col, [49:44] max_col
   logic [fnebb_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                                rsp_tlast;
   logic                                csr_we = 1'b0;
   logic [fnebb_pkg::CSR_ADDR_W-1:0]    csr_addr = '0;
   logic [fnebb_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   four_neighbor_erosion_bbox #(.MAX_WIDTH(MAX_W)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   typedef struct packed {
      logic [9:0] row;
      logic [5:0] col;
      logic       land;
      logic       is_last;
      logic       box_valid;
      logic [9:0] min_row;
      logic [9:0] max_row;
      logic [5:0] min_col;
      logic [5:0] max_col;
   } eroded_pixel_type;

   bit               pixel_q[$];
   eroded_pixel_type eroded_q[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned mismatches = 0;
   int unsigned rsp_count = 0;
   int unsigned quiet_cycles = 0;
   bit          req_sent = 1'b0;

   // shadow of the map geometry and the erosion window
   logic [5:0]  cfg_width = fnebb_pkg::WIDTH_RESET;
   logic [9:0]  cfg_height = fnebb_pkg::HEIGHT_RESET;
   bit          mid_line[MAX_W];
   bit          up_line[MAX_W];
   bit          left_mid = 1'b0;
   int unsigned row_cnt = 0;
   int unsigned col_cnt = 0;
   logic [9:0]  bb_min_row = '1;
   logic [9:0]  bb_max_row = '0;
   logic [5:0]  bb_min_col = '1;
   logic [5:0]  bb_max_col = '0;
   bit          land_seen = 1'b0;

   function automatic bit keeps_land(input bit center, input bit up, input bit down,
                                     input bit lf, input bit rt);
      int unsigned land_nbrs;
      land_nbrs = up + down + lf + rt;
      return center && (land_nbrs >= 2);
   endfunction

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_W) return MAX_W;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   task automatic record_pixel(input int unsigned r, input int unsigned c, input bit land,
                               input bit final_px);
      eroded_pixel_type px;
      px = '0;
      px.row = r[9:0];
      px.col = c[5:0];
      px.land = land;
      if (land) begin
         if (px.row < bb_min_row) bb_min_row = px.row;
         if (px.row > bb_max_row) bb_max_row = px.row;
         if (px.col < bb_min_col) bb_min_col = px.col;
         if (px.col > bb_max_col) bb_max_col = px.col;
         land_seen = 1'b1;
      end
      if (final_px) begin
         px.is_last = 1'b1;
         if (land_seen) begin
            px.box_valid = 1'b1;
            px.min_row = bb_min_row;
            px.max_row = bb_max_row;
            px.min_col = bb_min_col;
            px.max_col = bb_max_col;
         end
      end
      eroded_q.insert(eroded_q.size(), px);
   endtask

   // one accepted pixel: pixel above it in the window is decided now
   task automatic erode_step(input bit land_in);
      int unsigned w, h, r, c, j;
      bit mid, up, lf, rt, u;
      w = eff_width();
      h = eff_height();
      r = row_cnt;
      c = col_cnt;
      mid = mid_line[c];
      up = (r >= 2) ? up_line[c] : 1'b0;
      lf = (c > 0) ? left_mid : 1'b0;
      rt = (c + 1 < w) ? mid_line[c + 1] : 1'b0;
      if (r >= 1) record_pixel(r - 1, c, keeps_land(mid, up, land_in, lf, rt), 1'b0);
      left_mid = mid;
      up_line[c] = mid;
      mid_line[c] = land_in;
      if (c + 1 >= w) begin
         if (r + 1 >= h) begin
            // bottom row has no neighbor below
            for (j = 0; j < w; j++) begin
               u = (r >= 1) ? up_line[j] : 1'b0;
               lf = (j > 0) ? mid_line[j - 1] : 1'b0;
               rt = (j + 1 < w) ? mid_line[j + 1] : 1'b0;
               record_pixel(r, j, keeps_land(mid_line[j], u, 1'b0, lf, rt), j == w - 1);
            end
            row_cnt = 0;
            col_cnt = 0;
            bb_min_row = '1;
            bb_max_row = '0;
            bb_min_col = '1;
            bb_max_col = '0;
            land_seen = 1'b0;
         end else begin
            row_cnt = r + 1;
            col_cnt = 0;
         end
      end else begin
         col_cnt = c + 1;
      end
   endtask

   task automatic check_field(input string fname, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: %s expected %0d, got %0d", rsp_count, fname, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      eroded_pixel_type want;
      req_sent = req_tvalid && req_tready;
      if (!reset) begin
         if (req_sent) erode_step(req_tdata[0]);
         if (rsp_tvalid && rsp_tready) begin
            if (eroded_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: transfer with nothing expected", rsp_count);
            end else begin
               want = eroded_q.pop_front();
               check_field("out_row", want.row, rsp_tdata[9:0]);
               check_field("out_col", want.col, rsp_tdata[15:10]);
               check_field("land_after", want.land, rsp_tdata[16]);
               check_field("last", want.is_last, rsp_tlast);
               check_field("box_valid", want.box_valid, rsp_tdata[17]);
               check_field("min_row", want.min_row, rsp_tdata[27:18]);
               check_field("max_row", want.max_row, rsp_tdata[37:28]);
               check_field("min_col", want.min_col, rsp_tdata[43:38]);
               check_field("max_col", want.max_col, rsp_tdata[49:44]);
            end
            rsp_count++;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_sent) begin
         if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= {{(fnebb_pkg::REQ_DATA_W-1){1'b0}}, pixel_q.pop_front()};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("four_neighbor_erosion_bbox_tb: errors");
         $finish;
      end
   end

   task automatic drain();
      while (pixel_q.size() != 0 || req_tvalid || eroded_q.size() != 0) @(posedge clock);
      repeat (HOLD_CYCLES) @(posedge clock);
   endtask

   task automatic set_shape(input logic [5:0] wv, input logic [9:0] hv);
      logic [3:0] junk;
      drain();
      junk = 4'($urandom_range(0, 15));
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= fnebb_pkg::CSR_WIDTH;
      csr_wdata <= {junk, wv};   // bits above the width register are ignored
      @(negedge clock);
      csr_addr <= fnebb_pkg::CSR_HEIGHT;
      csr_wdata <= hv;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_width = wv;
      cfg_height = hv;
   endtask

   // back-to-back maps of random content at the current geometry
   task automatic add_maps(input int unsigned maps, inout int unsigned items);
      int unsigned m, k, pct, px_count;
      px_count = eff_width() * eff_height();
      for (m = 0; m < maps; m++) begin
         pct = $urandom_range(10, 100);
         for (k = 0; k < px_count; k++)
            pixel_q.insert(pixel_q.size(), $urandom_range(0, 99) < pct);
         items += px_count;
      end
   endtask

   initial begin : stimulus
      int unsigned items;
      int i;
      logic [8:0] plus_shape;
      items = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_idle_pct = 65;
      // geometry out of reset
      add_maps(1, items);

      // all land: every pixel has two or more land neighbors
      set_shape(6'd4, 10'd3);
      repeat (12) pixel_q.insert(pixel_q.size(), 1'b1);
      // zero geometry counts as one pixel; a lone pixel never survives
      set_shape(6'd0, 10'd0);
      pixel_q.insert(pixel_q.size(), 1'b1);
      pixel_q.insert(pixel_q.size(), 1'b0);
      // plus sign: only the center keeps enough land around it
      set_shape(6'd3, 10'd3);
      plus_shape = 9'b010_111_010;
      for (i = 8; i >= 0; i--) pixel_q.insert(pixel_q.size(), plus_shape[i]);
      drain();

      send_idle_pct = 65;
      recv_idle_pct = 8;
      items = 0;
      while (items < 10) begin
         set_shape(6'($urandom_range(0, 7)), 10'($urandom_range(0, 4)));
         add_maps($urandom_range(1, 2), items);
      end
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      items = 0;
      while (items < 10) begin
         set_shape(6'($urandom_range(0, 7)), 10'($urandom_range(0, 4)));
         add_maps($urandom_range(1, 2), items);
      end
      // width past the line buffers saturates
      set_shape(6'd63, 10'd1);
      add_maps(1, items);

      drain();
      repeat (HOLD_CYCLES) @(posedge clock);
      if (mismatches == 0 && eroded_q.size() == 0) begin
         $display("four_neighbor_erosion_bbox_tb: clean");
      end else begin
         $display("four_neighbor_erosion_bbox_tb: errors");
      end
      $finish;
   end

endmodule
